### design/stroke_speed_profile_table_macros.svh
// Assertion macros shared by the stroke speed profile table RTL.
`ifndef STROKE_SPEED_PROFILE_TABLE_MACROS_SVH
`define STROKE_SPEED_PROFILE_TABLE_MACROS_SVH

// Checked on every clk edge outside reset.
`define SSPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define SSPT_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/sspt_pkg.sv
// Types, codes and constants of the stroke speed profile table.
package sspt_pkg;

    localparam int TABLE_SIZE_DEF = 1024;

    localparam int SUM_W   = 24;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CNT_W-1:0] MIN_STROKE_RST = 16'd100;
    localparam logic [7:0]       STOP_TICKS_RST = 8'd10;

    // shared bit-serial divider
    localparam int DIV_NUM_W  = 41;     // avg*n + sum
    localparam int DIV_DEN_W  = 17;     // 2*d or n+1
    localparam int IDX_Q_W    = 26;     // 2*sum + d
    localparam int DIV_CNT_W  = 6;
    localparam logic [DIV_CNT_W-1:0] IDX_STEPS = 6'd26;
    localparam logic [DIV_CNT_W-1:0] AVG_STEPS = 6'd41;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] KIND_RECORDED = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_DROPPED  = 2'd2;

    localparam logic [1:0] DIR_STOPPED = 2'd0;
    localparam logic [1:0] DIR_RIGHT   = 2'd1;
    localparam logic [1:0] DIR_LEFT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STROKE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0] avg;
        logic [CNT_W-1:0] cnt;
    } sspt_entry_t;

    function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

### design/stroke_speed_profile_table.sv
// Stroke speed profile table: stroke tracking, speed index and table update.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------------
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//  item    | in  | item_valid/stall    | opcode, delta_x, table_index, write_average/count
//  result  | out | result_valid/stall  | result_kind, entry_index/average/count, sum
//
// Motion ticks that close nothing and write requests are done in S_IDLE; reads pass S_RDOUT, S_DONE.
// A recorded stroke runs through the bit-serial divider twice:
// 26 steps for the speed index, then 41 steps for the running average.
// After reset the table is cleared one entry a cycle;
// items stall meanwhile, config writes are always taken.
// A finished result waits in the output register; the next request can be
// taken meanwhile, but its own result waits until the register frees.
`include "stroke_speed_profile_table_macros.svh"

module stroke_speed_profile_table
    import sspt_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]           cfg_data,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            opcode,
    input  logic signed [15:0]    delta_x,
    input  logic [9:0]            table_index,
    input  logic [23:0]           write_average,
    input  logic [15:0]           write_count,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [1:0]            result_kind,
    output logic [15:0]           entry_index,
    output logic [23:0]           entry_average,
    output logic [15:0]           entry_count,
    output logic [23:0]           closed_stroke_sum
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam logic [16:0]   TSZ17     = 17'(TABLE_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DIV1   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_DIV2LD = 4'd5;
    localparam logic [3:0] S_DIV2   = 4'd6;
    localparam logic [3:0] S_RDOUT  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // control
    logic [3:0]           state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [15:0]          min_stroke_reg;
    logic [7:0]           stop_ticks_reg;
    logic [1:0]           dir_reg, dir_next;
    logic [SUM_W-1:0]     stroke_sum_reg, stroke_sum_next;
    logic [CNT_W-1:0]     tick_count_reg, tick_count_next;
    logic [CNT_W-1:0]     idle_count_reg, idle_count_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 result_valid_reg;

    // working payload
    logic [DIV_DEN_W-1:0] div_rem_reg, div_rem_next;
    logic [DIV_NUM_W-1:0] div_q_reg, div_q_next;
    logic [DIV_DEN_W-1:0] div_den_reg, div_den_next;
    logic [IDX_Q_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]     close_sum_reg, close_sum_next;
    logic [1:0]           wk_kind_reg, wk_kind_next;
    logic [SUM_W-1:0]     wk_avg_reg, wk_avg_next;
    logic [CNT_W-1:0]     wk_cnt_reg, wk_cnt_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [39:0]          prod_reg;
    logic                 rd_ok_reg, rd_ok_next;

    // table memory
    sspt_entry_t          table_mem [TABLE_SIZE];
    sspt_entry_t          rd_data_reg;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    sspt_entry_t          mem_wdata;

    // output register
    logic [1:0]           out_kind_reg;
    logic [15:0]          out_index_reg;
    logic [SUM_W-1:0]     out_avg_reg;
    logic [CNT_W-1:0]     out_cnt_reg;
    logic [SUM_W-1:0]     out_sum_reg;
    logic                 out_load;

    // datapath helpers
    logic                 item_take;
    logic [16:0]          tidx17;
    logic                 tidx_ok;
    logic [AW-1:0]        tidx_addr;
    logic [15:0]          raw;
    logic [15:0]          mag;
    logic [1:0]           want_dir;
    logic [24:0]          sum_add;
    logic [CNT_W-1:0]     idle_inc;
    logic [CNT_W-1:0]     d_val;
    logic [IDX_Q_W-1:0]   num1;
    logic [DIV_DEN_W:0]   rem_sh, rem_diff;
    logic                 rem_ge;
    logic                 idx_ok;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;

    assign tidx17    = {7'd0, table_index};
    assign tidx_ok   = tidx17 < TSZ17;
    assign tidx_addr = tidx17[AW-1:0];

    assign raw      = delta_x;
    assign mag      = raw[15] ? (16'd0 - raw) : raw;
    assign want_dir = raw[15] ? DIR_LEFT : DIR_RIGHT;
    assign sum_add  = {1'b0, stroke_sum_reg} + 25'(mag);
    assign idle_inc = sat_inc16(idle_count_reg);
    assign d_val    = tick_count_reg - idle_count_reg;
    // round(sum/d) = (2*sum + d) / (2*d)
    assign num1     = IDX_Q_W'({stroke_sum_reg, 1'b0}) + IDX_Q_W'(d_val);

    assign rem_sh   = {div_rem_reg, div_q_reg[DIV_NUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, div_den_reg};
    assign rem_diff = rem_sh - {1'b0, div_den_reg};

    assign idx_ok   = {1'b0, idx_reg} < (IDX_Q_W+1)'(TABLE_SIZE);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        dir_next        = dir_reg;
        stroke_sum_next = stroke_sum_reg;
        tick_count_next = tick_count_reg;
        idle_count_next = idle_count_reg;
        div_cnt_next    = div_cnt_reg;
        div_rem_next    = div_rem_reg;
        div_q_next      = div_q_reg;
        div_den_next    = div_den_reg;
        idx_next        = idx_reg;
        close_sum_next  = close_sum_reg;
        wk_kind_next    = wk_kind_reg;
        wk_avg_next     = wk_avg_reg;
        wk_cnt_next     = wk_cnt_reg;
        n_next          = n_reg;
        rd_ok_next      = rd_ok_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg[AW-1:0];
        out_load        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_take)
                begin
                    unique case (opcode)
                        OP_TICK:
                        begin
                            if (raw == 16'd0)
                            begin
                                tick_count_next = sat_inc16(tick_count_reg);
                                idle_count_next = idle_inc;
                                if (idle_inc > {8'd0, stop_ticks_reg})
                                begin
                                    dir_next = DIR_STOPPED;
                                end
                            end
                            else if (dir_reg != want_dir)
                            begin
                                if (stroke_sum_reg > {8'd0, min_stroke_reg})
                                begin
                                    close_sum_next = stroke_sum_reg;
                                    if (idle_count_reg >= tick_count_reg)
                                    begin
                                        // no moving ticks: index all ones
                                        idx_next   = IDX_Q_W'(16'hFFFF);
                                        state_next = S_CHECK;
                                    end
                                    else
                                    begin
                                        div_q_next   = {num1,
                                                        {(DIV_NUM_W-IDX_Q_W){1'b0}}};
                                        div_rem_next = '0;
                                        div_den_next = {d_val, 1'b0};
                                        div_cnt_next = IDX_STEPS;
                                        state_next   = S_DIV1;
                                    end
                                end
                                dir_next        = want_dir;
                                stroke_sum_next = SUM_W'(mag);
                                tick_count_next = 16'd1;
                                idle_count_next = '0;
                            end
                            else
                            begin
                                stroke_sum_next = sum_add[24] ? SUM_MAX : sum_add[23:0];
                                tick_count_next = sat_inc16(tick_count_reg);
                                idle_count_next = '0;
                            end
                        end
                        OP_READ:
                        begin
                            mem_re         = tidx_ok;
                            mem_raddr      = tidx_addr;
                            rd_ok_next     = tidx_ok;
                            idx_next       = IDX_Q_W'(table_index);
                            close_sum_next = '0;
                            state_next     = S_RDOUT;
                        end
                        OP_WRITE:
                        begin
                            mem_we        = tidx_ok;
                            mem_waddr     = tidx_addr;
                            mem_wdata.avg = write_average;
                            mem_wdata.cnt = write_count;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV1:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_rem_next = rem_ge ? rem_diff[DIV_DEN_W-1:0]
                                          : rem_sh[DIV_DEN_W-1:0];
                    div_q_next   = {div_q_reg[DIV_NUM_W-2:0], rem_ge};
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
                else
                begin
                    idx_next   = div_q_reg[IDX_Q_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (idx_ok)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[AW-1:0];
                    state_next = S_MUL;
                end
                else
                begin
                    wk_kind_next = KIND_DROPPED;
                    wk_avg_next  = '0;
                    wk_cnt_next  = '0;
                    state_next   = S_DONE;
                end
            end
            S_MUL:
            begin
                n_next     = rd_data_reg.cnt;
                state_next = S_DIV2LD;
            end
            S_DIV2LD:
            begin
                div_q_next   = DIV_NUM_W'(prod_reg) + DIV_NUM_W'(close_sum_reg);
                div_rem_next = '0;
                div_den_next = DIV_DEN_W'(n_reg) + 17'd1;
                div_cnt_next = AVG_STEPS;
                state_next   = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_rem_next = rem_ge ? rem_diff[DIV_DEN_W-1:0]
                                          : rem_sh[DIV_DEN_W-1:0];
                    div_q_next   = {div_q_reg[DIV_NUM_W-2:0], rem_ge};
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
                else
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = idx_reg[AW-1:0];
                    mem_wdata.avg = div_q_reg[SUM_W-1:0];
                    mem_wdata.cnt = sat_inc16(n_reg);
                    wk_kind_next  = KIND_RECORDED;
                    wk_avg_next   = div_q_reg[SUM_W-1:0];
                    wk_cnt_next   = sat_inc16(n_reg);
                    state_next    = S_DONE;
                end
            end
            S_RDOUT:
            begin
                wk_kind_next = KIND_READ;
                wk_avg_next  = rd_ok_reg ? rd_data_reg.avg : '0;
                wk_cnt_next  = rd_ok_reg ? rd_data_reg.cnt : '0;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            min_stroke_reg   <= MIN_STROKE_RST;
            stop_ticks_reg   <= STOP_TICKS_RST;
            dir_reg          <= DIR_STOPPED;
            stroke_sum_reg   <= '0;
            tick_count_reg   <= '0;
            idle_count_reg   <= '0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            dir_reg        <= dir_next;
            stroke_sum_reg <= stroke_sum_next;
            tick_count_reg <= tick_count_next;
            idle_count_reg <= idle_count_next;
            div_cnt_reg    <= div_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIN_STROKE)
                begin
                    min_stroke_reg <= cfg_data;
                end
                else if (cfg_index == CFG_STOP_TICKS)
                begin
                    stop_ticks_reg <= cfg_data[7:0];
                end
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg   <= div_rem_next;
        div_q_reg     <= div_q_next;
        div_den_reg   <= div_den_next;
        idx_reg       <= idx_next;
        close_sum_reg <= close_sum_next;
        wk_kind_reg   <= wk_kind_next;
        wk_avg_reg    <= wk_avg_next;
        wk_cnt_reg    <= wk_cnt_next;
        n_reg         <= n_next;
        rd_ok_reg     <= rd_ok_next;
        prod_reg      <= rd_data_reg.avg * rd_data_reg.cnt;
        if (out_load)
        begin
            out_kind_reg  <= wk_kind_reg;
            out_index_reg <= (idx_reg[IDX_Q_W-1:16] != '0) ? 16'hFFFF : idx_reg[15:0];
            out_avg_reg   <= wk_avg_reg;
            out_cnt_reg   <= wk_cnt_reg;
            out_sum_reg   <= close_sum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_raddr];
        end
    end

    assign result_kind       = out_kind_reg;
    assign entry_index       = out_index_reg;
    assign entry_average     = out_avg_reg;
    assign entry_count       = out_cnt_reg;
    assign closed_stroke_sum = out_sum_reg;

    `SSPT_ASSERT(a_clear_once, (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR), "clear pass restarted")
    `SSPT_ASSERT(a_result_from_done, $rose(result_valid_reg) |-> ($past(state_reg) == S_DONE), "result without finished request")
    `SSPT_ASSERT(a_store_in_range, (mem_we && (state_reg == S_DIV2)) |-> idx_ok, "table update outside table")
    `SSPT_ASSERT(a_div_bound, div_cnt_reg <= AVG_STEPS, "divider step count out of range")
    `SSPT_ASSERT_NR(a_no_result_in_clear, result_valid_reg |-> (state_reg != S_CLEAR), "result during clear pass")

endmodule
